[design/dop_pkg.sv]
// Shared types and constants for the DHCP option parser.
package dop_pkg;

    localparam int OPTION_AREA_BYTES_DEF = 312;
    localparam int MIN_PACKET_BYTES_DEF  = 300;

    localparam int unsigned HEADER_BYTES = 236;
    localparam logic [31:0] COOKIE_WORD  = 32'h6382_5363;

    localparam int Q_DEPTH = 4;

    // result kinds
    localparam logic [4:0] KIND_OP        = 5'd0;
    localparam logic [4:0] KIND_XID       = 5'd4;
    localparam logic [4:0] KIND_SECS      = 5'd5;
    localparam logic [4:0] KIND_FLAGS     = 5'd6;
    localparam logic [4:0] KIND_CIADDR    = 5'd7;
    localparam logic [4:0] KIND_COOKIE    = 5'd11;
    localparam logic [4:0] KIND_MASK      = 5'd12;
    localparam logic [4:0] KIND_ROUTER    = 5'd13;
    localparam logic [4:0] KIND_DNS       = 5'd14;
    localparam logic [4:0] KIND_HOST_BYTE = 5'd15;
    localparam logic [4:0] KIND_DOM_BYTE  = 5'd16;
    localparam logic [4:0] KIND_MSGTYPE   = 5'd17;
    localparam logic [4:0] KIND_UNKNOWN   = 5'd18;
    localparam logic [4:0] KIND_END       = 5'd19;

    // option codes
    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_HOST    = 8'd12;
    localparam logic [7:0] OPT_DOMAIN  = 8'd15;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;
    localparam logic [7:0] OPT_END     = 8'd255;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic        string_end;
        logic        status;
        logic        is_dhcp;
        logic        last_of_run;
    } res_t;

    // up to two results caused by one byte: a parse result and the end record
    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } res_pair_t;

endpackage

[design/dop_in_if.sv]
// Byte request channel into the parser.
interface dop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/dop_out_if.sv]
// Result request channel out of the parser.
interface dop_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [31:0] value;
    logic        string_end;
    logic        status;
    logic        is_dhcp;
    logic        last_of_run;

    modport source (output valid, output kind, output value, output string_end,
                    output status, output is_dhcp, output last_of_run, input ready);
    modport sink   (input valid, input kind, input value, input string_end,
                    input status, input is_dhcp, input last_of_run, output ready);
endinterface

[design/dop_parse.sv]
// Parse state registers and per-byte result logic.
module dop_parse #(
    parameter int OPTION_AREA_BYTES = dop_pkg::OPTION_AREA_BYTES_DEF,
    parameter int MIN_PACKET_BYTES  = dop_pkg::MIN_PACKET_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output dop_pkg::res_pair_t results
);
    import dop_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_COOKIE = 7'b0000010,
        PH_TYPE   = 7'b0000100,
        PH_LEN    = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_IGNORE = 7'b1000000
    } phase_t;

    localparam logic [8:0] AREA_INIT = 9'(OPTION_AREA_BYTES);
    localparam logic [10:0] MIN_LEN  = 11'(MIN_PACKET_BYTES);

    logic [9:0]  bp_reg, bp_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  obl_reg, obl_next;
    logic        acc_ok_reg, acc_ok_next;
    logic [31:0] acc_reg, acc_next;
    logic [8:0]  area_reg, area_next;
    logic        dhcp_reg, dhcp_next;
    logic        trunc_reg, trunc_next;

    logic [8:0]  area_dec;
    logic [7:0]  obl_dec;
    phase_t      phase_after;
    logic [31:0] acc_shift;
    logic        end_trunc;

    always_comb
    begin
        area_dec    = (area_reg != 9'd0) ? area_reg - 9'd1 : area_reg;
        obl_dec     = (obl_reg != 8'd0) ? obl_reg - 8'd1 : obl_reg;
        phase_after = (area_dec == 9'd0) ? PH_DONE : PH_TYPE;
        acc_shift   = {acc_reg[23:0], data_byte};

        bp_next     = bp_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        obl_next    = obl_reg;
        acc_ok_next = acc_ok_reg;
        acc_next    = acc_reg;
        area_next   = area_reg;
        dhcp_next   = dhcp_reg;
        trunc_next  = trunc_reg;
        results     = '0;
        end_trunc   = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                acc_next = acc_shift;
                if (bp_reg <= 10'd3)
                begin
                    results.v0       = 1'b1;
                    results.r0.kind  = KIND_OP + 5'(bp_reg);
                    results.r0.value = {24'd0, data_byte};
                end
                else if (bp_reg == 10'd7)
                begin
                    results.v0       = 1'b1;
                    results.r0.kind  = KIND_XID;
                    results.r0.value = acc_shift;
                end
                else if (bp_reg == 10'd9 || bp_reg == 10'd11)
                begin
                    results.v0       = 1'b1;
                    results.r0.kind  = (bp_reg == 10'd9) ? KIND_SECS : KIND_FLAGS;
                    results.r0.value = {16'd0, acc_shift[15:0]};
                end
                else if (bp_reg == 10'd15 || bp_reg == 10'd19 ||
                         bp_reg == 10'd23 || bp_reg == 10'd27)
                begin
                    results.v0       = 1'b1;
                    results.r0.kind  = KIND_CIADDR + 5'((bp_reg - 10'd15) >> 2);
                    results.r0.value = acc_shift;
                end
                if (bp_reg >= 10'(HEADER_BYTES - 1))
                    phase_next = PH_COOKIE;
            end
            PH_COOKIE:
            begin
                acc_next  = acc_shift;
                area_next = area_dec;
                if (bp_reg >= 10'(HEADER_BYTES + 3))
                begin
                    if (acc_shift == COOKIE_WORD)
                    begin
                        results.v0       = 1'b1;
                        results.r0.kind  = KIND_COOKIE;
                        results.r0.value = COOKIE_WORD;
                        phase_next       = phase_after;
                    end
                    else
                        phase_next = PH_IGNORE;
                end
            end
            PH_TYPE:
            begin
                area_next = area_dec;
                if (data_byte == OPT_PAD)
                    phase_next = phase_after;
                else if (data_byte == OPT_END)
                    phase_next = PH_DONE;
                else
                begin
                    code_next = data_byte;
                    if (data_byte == OPT_MSGTYPE)
                        dhcp_next = 1'b1;
                    if (area_dec == 9'd0)
                    begin
                        trunc_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                area_next = area_dec;
                if ({1'b0, data_byte} > area_dec)
                begin
                    trunc_next = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    case (code_reg)
                        OPT_MASK:               acc_ok_next = (data_byte == 8'd4);
                        OPT_ROUTER, OPT_DNS:    acc_ok_next = (data_byte[1:0] == 2'd0);
                        OPT_HOST, OPT_DOMAIN:   acc_ok_next = 1'b1;
                        OPT_MSGTYPE:            acc_ok_next = (data_byte == 8'd1);
                        default:
                        begin
                            acc_ok_next      = 1'b0;
                            results.v0       = 1'b1;
                            results.r0.kind  = KIND_UNKNOWN;
                            results.r0.value = {24'd0, code_reg};
                        end
                    endcase
                    obl_next   = data_byte;
                    acc_next   = 32'd0;
                    phase_next = (data_byte == 8'd0) ? phase_after : PH_DATA;
                end
            end
            PH_DATA:
            begin
                area_next = area_dec;
                obl_next  = obl_dec;
                if (acc_ok_reg)
                begin
                    case (code_reg)
                        OPT_MASK, OPT_ROUTER, OPT_DNS:
                        begin
                            acc_next = acc_shift;
                            if (obl_dec[1:0] == 2'd0)
                            begin
                                results.v0       = 1'b1;
                                results.r0.kind  = (code_reg == OPT_MASK)   ? KIND_MASK :
                                                   (code_reg == OPT_ROUTER) ? KIND_ROUTER :
                                                                              KIND_DNS;
                                results.r0.value = acc_shift;
                            end
                        end
                        OPT_HOST, OPT_DOMAIN:
                        begin
                            results.v0            = 1'b1;
                            results.r0.kind       = (code_reg == OPT_HOST) ? KIND_HOST_BYTE
                                                                           : KIND_DOM_BYTE;
                            results.r0.value      = {24'd0, data_byte};
                            results.r0.string_end = (obl_dec == 8'd0);
                        end
                        OPT_MSGTYPE:
                        begin
                            results.v0       = 1'b1;
                            results.r0.kind  = KIND_MSGTYPE;
                            results.r0.value = {24'd0, data_byte};
                        end
                        default: ;
                    endcase
                end
                if (obl_dec == 8'd0)
                    phase_next = phase_after;
            end
            default: ;
        endcase

        if (bp_reg != 10'd1023)
            bp_next = bp_reg + 10'd1;

        if (last_byte)
        begin
            end_trunc = trunc_next || ({1'b0, bp_next} < MIN_LEN) ||
                        phase_next == PH_LEN || phase_next == PH_DATA;
            results.v1                = 1'b1;
            results.r1.kind           = KIND_END;
            results.r1.status         = end_trunc;
            results.r1.is_dhcp        = dhcp_next;
            results.r1.last_of_run    = 1'b1;

            bp_next     = 10'd0;
            phase_next  = PH_HEADER;
            code_next   = 8'd0;
            obl_next    = 8'd0;
            acc_ok_next = 1'b0;
            acc_next    = 32'd0;
            area_next   = AREA_INIT;
            dhcp_next   = 1'b0;
            trunc_next  = 1'b0;
        end
        else
            results.r0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg     <= 10'd0;
            phase_reg  <= PH_HEADER;
            code_reg   <= 8'd0;
            obl_reg    <= 8'd0;
            acc_ok_reg <= 1'b0;
            acc_reg    <= 32'd0;
            area_reg   <= AREA_INIT;
            dhcp_reg   <= 1'b0;
            trunc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bp_reg     <= bp_next;
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            obl_reg    <= obl_next;
            acc_ok_reg <= acc_ok_next;
            acc_reg    <= acc_next;
            area_reg   <= area_next;
            dhcp_reg   <= dhcp_next;
            trunc_reg  <= trunc_next;
        end
    end

endmodule

[design/dop_outq.sv]
// Result queue: takes up to two results a cycle, hands out one.
module dop_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dop_pkg::res_pair_t results,
    output logic               room,
    output logic               valid,
    input  logic               ready,
    output dop_pkg::res_t      head
);
    import dop_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    res_t            q_reg [Q_DEPTH];
    logic [AW-1:0]   head_reg, tail_reg;
    logic [AW:0]     count_reg, count_next;
    logic [AW-1:0]   tail_plus1;
    logic [1:0]      n_push;
    logic            pop;
    res_t            wr_a;

    assign room       = (count_reg <= (AW+1)'(Q_DEPTH - 2));
    assign valid      = (count_reg != '0);
    assign head       = q_reg[head_reg];
    assign pop        = valid && ready;
    assign tail_plus1 = tail_reg + AW'(1);
    assign wr_a       = results.v0 ? results.r0 : results.r1;
    assign n_push     = push ? ({1'b0, results.v0} + {1'b0, results.v1}) : 2'd0;
    assign count_next = count_reg + (AW+1)'(n_push) - (AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_reg[tail_reg] <= wr_a;
        if (n_push == 2'd2)
            q_reg[tail_plus1] <= results.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + AW'(1);
            tail_reg  <= tail_reg + AW'(n_push);
            count_reg <= count_next;
        end
    end

endmodule

[design/dhcp_option_parser_core.sv]
// Top level of the BOOTP/DHCP option parser.
//
//  channel | dir | payload                                   | one request is
//  --------+-----+-------------------------------------------+-------------------
//  pkt     | in  | data_byte, last_byte                      | one packet byte
//  res     | out | kind, value, string_end, status, is_dhcp, | one parse result
//          |     | last_of_run                               |
//
// A byte is taken every cycle while the queue has room; its results are registered
// into a 4-entry queue. A byte gives at most two results (its own and the end
// record); pkt.ready drops only when the queue holds more than two results.
// Reset clears all parse state and empties the queue; no clearing pass follows.
module dhcp_option_parser_core #(
    parameter int OPTION_AREA_BYTES = dop_pkg::OPTION_AREA_BYTES_DEF,
    parameter int MIN_PACKET_BYTES  = dop_pkg::MIN_PACKET_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dop_in_if.sink    pkt,
    dop_out_if.source res
);
    import dop_pkg::*;

    res_pair_t results;
    res_t      head;
    logic      accept;
    logic      room;

    assign pkt.ready = room;
    assign accept    = pkt.valid && room;

    dop_parse #(
        .OPTION_AREA_BYTES (OPTION_AREA_BYTES),
        .MIN_PACKET_BYTES  (MIN_PACKET_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (pkt.data_byte),
        .last_byte (pkt.last_byte),
        .results   (results)
    );

    dop_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .results (results),
        .room    (room),
        .valid   (res.valid),
        .ready   (res.ready),
        .head    (head)
    );

    assign res.kind        = head.kind;
    assign res.value       = head.value;
    assign res.string_end  = head.string_end;
    assign res.status      = head.status;
    assign res.is_dhcp     = head.is_dhcp;
    assign res.last_of_run = head.last_of_run;

endmodule

[design/dop_checker.sv]
// Port-level assertions for the parser, bound to the top level.
module dop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [4:0]  res_kind,
    input logic        res_string_end,
    input logic        res_status,
    input logic        res_is_dhcp,
    input logic        res_last_of_run
);
    import dop_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_kind <= KIND_END)
        else $error("result kind out of range");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_END |-> res_last_of_run)
        else $error("end record not marked last of run");

    a_status_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status || res_is_dhcp) |-> res_kind == KIND_END)
        else $error("status or dhcp flag outside end record");

    a_string_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_string_end |->
            (res_kind == KIND_HOST_BYTE || res_kind == KIND_DOM_BYTE))
        else $error("string end on a non-string result");

endmodule

bind dhcp_option_parser_core dop_checker u_dop_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_kind        (res.kind),
    .res_string_end  (res.string_end),
    .res_status      (res.status),
    .res_is_dhcp     (res.is_dhcp),
    .res_last_of_run (res.last_of_run)
);
